### src/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

    localparam int MAX_SEQ_NUM  = 7;
    localparam int WINDOW_MAX   = 7;
    localparam int STORE_SLOTS  = 8;
    localparam int DATA_BITS    = 32;

    localparam int SEQ_W        = 3;
    localparam int CNT_W        = 32;
    localparam int LIM_W        = 8;
    localparam int STORE_ADDR_W = $clog2(STORE_SLOTS);

    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 3;
    localparam int M_TDATA_W    = 80;
    localparam int M_TUSER_W    = 2;
    localparam int M_PAD_W      = M_TDATA_W - (4 * SEQ_W + DATA_BITS + CNT_W);

    typedef enum logic [1:0] {
        REQ_NEW     = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_SENT    = 2'd0,
        KIND_ACKED   = 2'd1,
        KIND_REFUSED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_RESEND
    } st_t;

    typedef struct packed {
        req_t                 op;
        logic [DATA_BITS-1:0] payload;
        logic [SEQ_W-1:0]     ack_seq;
    } cmd_t;

    typedef struct packed {
        kind_t                kind;
        logic [SEQ_W-1:0]     seq;
        logic [DATA_BITS-1:0] frame_data;
        logic [SEQ_W-1:0]     outstanding;
        logic [SEQ_W-1:0]     window_base;
        logic [SEQ_W-1:0]     window_next;
        logic [CNT_W-1:0]     sent_count;
        logic                 last;
    } res_t;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        logic [LIM_W-1:0] w;
        w = LIM_W'(s);
        if (w == LIM_W'(MAX_SEQ_NUM)) begin
            return '0;
        end
        return SEQ_W'(w + LIM_W'(1));
    endfunction

    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function automatic logic [SEQ_W-1:0] eff_limit(input logic [SEQ_W-1:0] lim);
        logic [LIM_W-1:0] l;
        l = LIM_W'(lim);
        if (l > LIM_W'(WINDOW_MAX)) begin
            l = LIM_W'(WINDOW_MAX);
        end
        if (l > LIM_W'(MAX_SEQ_NUM)) begin
            l = LIM_W'(MAX_SEQ_NUM);
        end
        return SEQ_W'(l);
    endfunction

endpackage

### src/gbn_ram.sv
`timescale 1ns / 1ps

module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gbn_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [gbn_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          cmd_valid,
    output gbn_pkg::cmd_t                 cmd,
    input  logic                          cmd_pop
);

    gbn_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          keep;
    logic          push;
    gbn_pkg::cmd_t in_cmd;

    // classify: drop corrupt acks and unknown requests
    always_comb begin
        in_cmd.op      = gbn_pkg::req_t'(s_tuser[1:0]);
        in_cmd.payload = s_tdata[gbn_pkg::DATA_BITS-1:0];
        in_cmd.ack_seq = s_tdata[gbn_pkg::DATA_BITS +: gbn_pkg::SEQ_W];
        unique case (s_tuser[1:0])
            gbn_pkg::REQ_NEW:     keep = 1'b1;
            gbn_pkg::REQ_ACK:     keep = ~s_tuser[2];
            gbn_pkg::REQ_TIMEOUT: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid & s_tready & keep;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### src/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [gbn_pkg::SEQ_W-1:0] cfg_wr_data,
    input  logic                      cmd_valid,
    input  gbn_pkg::cmd_t             cmd,
    output logic                      cmd_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output gbn_pkg::res_t             res
);

    localparam int AW = gbn_pkg::STORE_ADDR_W;
    localparam int SW = gbn_pkg::SEQ_W;

    gbn_pkg::st_t             state_reg, state_next;
    logic [SW-1:0]            base_reg, base_next;
    logic [SW-1:0]            nseq_reg, nseq_next;
    logic [SW-1:0]            flight_reg, flight_next;
    logic [gbn_pkg::CNT_W-1:0] sent_reg, sent_next;
    logic [SW-1:0]            cnt_reg, cnt_next;
    logic [SW-1:0]            cur_reg, cur_next;
    logic [SW-1:0]            ack_reg, ack_next;
    logic [SW-1:0]            lim_reg;
    logic                     m_valid_reg, m_valid_next;
    gbn_pkg::res_t            res_reg, res_next;
    logic                     out_free;
    logic                     load;
    logic                     ram_we;
    logic [gbn_pkg::DATA_BITS-1:0] ram_rdata;

    gbn_ram #(
        .WIDTH (gbn_pkg::DATA_BITS),
        .DEPTH (gbn_pkg::STORE_SLOTS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (nseq_reg[AW-1:0]),
        .wdata (cmd.payload),
        .raddr (cur_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free = ~m_valid_reg | m_tready;

    always_comb begin
        state_next  = state_reg;
        base_next   = base_reg;
        nseq_next   = nseq_reg;
        flight_next = flight_reg;
        sent_next   = sent_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        ack_next    = ack_reg;
        res_next    = res_reg;
        load        = 1'b0;
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        unique case (state_reg)
            gbn_pkg::ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        gbn_pkg::REQ_NEW: begin
                            load = 1'b1;
                            if (flight_reg >= gbn_pkg::eff_limit(lim_reg)) begin
                                res_next.kind        = gbn_pkg::KIND_REFUSED;
                                res_next.seq         = '0;
                                res_next.frame_data  = '0;
                                res_next.outstanding = flight_reg;
                                res_next.window_base = base_reg;
                                res_next.window_next = nseq_reg;
                                res_next.sent_count  = sent_reg;
                            end else begin
                                ram_we      = 1'b1;
                                flight_next = flight_reg + SW'(1);
                                sent_next   = sent_reg + gbn_pkg::CNT_W'(1);
                                nseq_next   = gbn_pkg::seq_inc(nseq_reg);
                                res_next.kind        = gbn_pkg::KIND_SENT;
                                res_next.seq         = nseq_reg;
                                res_next.frame_data  = cmd.payload;
                                res_next.outstanding = flight_next;
                                res_next.window_base = base_reg;
                                res_next.window_next = nseq_next;
                                res_next.sent_count  = sent_next;
                            end
                            res_next.last = 1'b1;
                        end
                        gbn_pkg::REQ_ACK: begin
                            ack_next = cmd.ack_seq;
                            if ((flight_reg != '0) &&
                                gbn_pkg::in_window(base_reg, cmd.ack_seq, nseq_reg)) begin
                                state_next = gbn_pkg::ST_ACK;
                            end
                        end
                        gbn_pkg::REQ_TIMEOUT: begin
                            cur_next = base_reg;
                            cnt_next = flight_reg;
                            if (flight_reg != '0) begin
                                state_next = gbn_pkg::ST_RESEND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            gbn_pkg::ST_ACK: begin
                if (out_free) begin
                    load        = 1'b1;
                    flight_next = flight_reg - SW'(1);
                    base_next   = gbn_pkg::seq_inc(base_reg);
                    res_next.kind        = gbn_pkg::KIND_ACKED;
                    res_next.seq         = base_reg;
                    res_next.frame_data  = '0;
                    res_next.outstanding = flight_next;
                    res_next.window_base = base_next;
                    res_next.window_next = nseq_reg;
                    res_next.sent_count  = sent_reg;
                    res_next.last        = (base_reg == ack_reg);
                    if (base_reg == ack_reg) begin
                        state_next = gbn_pkg::ST_IDLE;
                    end
                end
            end
            gbn_pkg::ST_RESEND: begin
                if (out_free) begin
                    load      = 1'b1;
                    sent_next = sent_reg + gbn_pkg::CNT_W'(1);
                    cur_next  = gbn_pkg::seq_inc(cur_reg);
                    cnt_next  = cnt_reg - SW'(1);
                    res_next.kind        = gbn_pkg::KIND_SENT;
                    res_next.seq         = cur_reg;
                    res_next.frame_data  = ram_rdata;
                    res_next.outstanding = flight_reg;
                    res_next.window_base = base_reg;
                    res_next.window_next = nseq_reg;
                    res_next.sent_count  = sent_next;
                    res_next.last        = (cnt_reg == SW'(1));
                    if (cnt_reg == SW'(1)) begin
                        state_next = gbn_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = gbn_pkg::ST_IDLE;
        endcase
        m_valid_next = load | (m_valid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gbn_pkg::ST_IDLE;
            base_reg    <= '0;
            nseq_reg    <= '0;
            flight_reg  <= '0;
            sent_reg    <= '0;
            cnt_reg     <= '0;
            cur_reg     <= '0;
            lim_reg     <= SW'(gbn_pkg::WINDOW_MAX);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            nseq_reg    <= nseq_next;
            flight_reg  <= flight_next;
            sent_reg    <= sent_next;
            cnt_reg     <= cnt_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                lim_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ack_reg <= ack_next;
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign res      = res_reg;

`ifndef SYNTHESIS
    a_window_span: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'(nseq_reg - base_reg) == flight_reg)
        else $error("window span disagrees with outstanding count");

    a_ack_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gbn_pkg::ST_ACK |-> flight_reg != '0)
        else $error("retiring frames with nothing outstanding");

    a_resend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gbn_pkg::ST_RESEND |-> (cnt_reg != '0) && (cnt_reg <= flight_reg))
        else $error("resend count out of range");

    a_sent_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (sent_reg != $past(sent_reg)) |->
            sent_reg == $past(sent_reg) + gbn_pkg::CNT_W'(1))
        else $error("sent total moved by more than one");
`endif

endmodule

### src/go_back_n_sender_core.sv
`timescale 1ns / 1ps

// Go-Back-N sender. Requests enter through a two-entry command queue and are
// executed one at a time by the window engine, which emits one result per
// cycle into an output register while that register is free. A new packet
// gives one result. An ack or a timeout is first decoded, then gives one result
// for each frame it retires or resends, up to seven results in all. A corrupt
// ack or an unknown request is dropped at the queue input and costs the engine
// nothing. An ack outside the window, or a timeout with nothing outstanding,
// is decoded and gives no result.
// The payload store is a registered-read RAM read one frame ahead of the
// resend pointer. Results stall without loss while m_tready is low.

module go_back_n_sender_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gbn_pkg::SEQ_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] payload, [34:32] ack_seq, [39:35] zero
    input  logic [gbn_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type, [2] corrupt
    input  logic [gbn_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] seq, [34:3] frame_data, [37:35] outstanding, [40:38] window_base,
    // [43:41] window_next, [75:44] sent_count, [79:76] zero
    output logic [gbn_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [gbn_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    logic          cmd_valid;
    logic          cmd_pop;
    gbn_pkg::cmd_t cmd;
    gbn_pkg::res_t res;

    gbn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    gbn_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res         (res)
    );

    assign m_tdata = {{gbn_pkg::M_PAD_W{1'b0}}, res.sent_count, res.window_next,
                      res.window_base, res.outstanding, res.frame_data, res.seq};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

### tb/gbn_sender_checker.sv
`timescale 1ns / 1ps

module gbn_sender_checker
    import gbn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [SEQ_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending_count
);

    logic [SEQ_W-1:0]     window_limit;
    logic [SEQ_W-1:0]     oldest_seq;
    logic [SEQ_W-1:0]     upcoming_seq;
    logic [SEQ_W-1:0]     frames_out;
    logic [CNT_W-1:0]     frames_sent;
    logic [DATA_BITS-1:0] sent_payloads [STORE_SLOTS];
    res_t                 due_frames [$];
    int                   mismatches = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("checker: %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic queue_frame(input kind_t k, input logic [SEQ_W-1:0] sq,
                               input logic [DATA_BITS-1:0] d, input logic lst);
        res_t ev;
        ev.kind        = k;
        ev.seq         = sq;
        ev.frame_data  = d;
        ev.outstanding = frames_out;
        ev.window_base = oldest_seq;
        ev.window_next = upcoming_seq;
        ev.sent_count  = frames_sent;
        ev.last        = lst;
        due_frames.push_back(ev);
    endtask

    task automatic apply_request(input logic [1:0] req, input logic [DATA_BITS-1:0] payload,
                                 input logic [SEQ_W-1:0] ack, input logic bad);
        logic [SEQ_W-1:0] cap;
        logic [SEQ_W-1:0] ack_dist;
        logic [SEQ_W-1:0] next_dist;
        logic [SEQ_W-1:0] sq;
        int               n;
        cap = window_limit;
        if (cap > WINDOW_MAX) begin
            cap = SEQ_W'(WINDOW_MAX);
        end
        if (cap > MAX_SEQ_NUM) begin
            cap = SEQ_W'(MAX_SEQ_NUM);
        end
        case (req)
            REQ_NEW: begin
                if (frames_out >= cap) begin
                    queue_frame(KIND_REFUSED, '0, '0, 1'b1);
                end else begin
                    sq                = upcoming_seq;
                    sent_payloads[sq] = payload;
                    frames_out        = frames_out + 1'b1;
                    frames_sent       = frames_sent + 1'b1;
                    upcoming_seq      = upcoming_seq + 1'b1;
                    queue_frame(KIND_SENT, sq, payload, 1'b1);
                end
            end
            REQ_ACK: begin
                ack_dist  = ack - oldest_seq;
                next_dist = upcoming_seq - oldest_seq;
                if (!bad && ack_dist < next_dist) begin
                    n = int'(ack_dist) + 1;
                    for (int i = 0; i < n; i++) begin
                        sq         = oldest_seq;
                        oldest_seq = oldest_seq + 1'b1;
                        frames_out = frames_out - 1'b1;
                        queue_frame(KIND_ACKED, sq, '0, i == n - 1);
                    end
                end
            end
            REQ_TIMEOUT: begin
                sq = oldest_seq;
                n  = int'(frames_out);
                for (int i = 0; i < n; i++) begin
                    frames_sent = frames_sent + 1'b1;
                    queue_frame(KIND_SENT, sq, sent_payloads[sq], i == n - 1);
                    sq = sq + 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        res_t want;
        if (due_frames.size() == 0) begin
            flag_mismatch("result with nothing expected, seq", 32'(m_tdata[2:0]), 32'd0);
            return;
        end
        want = due_frames.pop_front();
        if (m_tuser[1:0] != want.kind) begin
            flag_mismatch("kind", 32'(m_tuser[1:0]), 32'(want.kind));
        end
        if (m_tdata[2:0] != want.seq) begin
            flag_mismatch("seq", 32'(m_tdata[2:0]), 32'(want.seq));
        end
        if (m_tdata[34:3] != want.frame_data) begin
            flag_mismatch("frame_data", m_tdata[34:3], want.frame_data);
        end
        if (m_tdata[37:35] != want.outstanding) begin
            flag_mismatch("outstanding", 32'(m_tdata[37:35]), 32'(want.outstanding));
        end
        if (m_tdata[40:38] != want.window_base) begin
            flag_mismatch("window_base", 32'(m_tdata[40:38]), 32'(want.window_base));
        end
        if (m_tdata[43:41] != want.window_next) begin
            flag_mismatch("window_next", 32'(m_tdata[43:41]), 32'(want.window_next));
        end
        if (m_tdata[75:44] != want.sent_count) begin
            flag_mismatch("sent_count", m_tdata[75:44], want.sent_count);
        end
        if (m_tlast != want.last) begin
            flag_mismatch("last", 32'(m_tlast), 32'(want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            window_limit = 3'd7;
            oldest_seq   = '0;
            upcoming_seq = '0;
            frames_out   = '0;
            frames_sent  = '0;
            due_frames.delete();
        end else begin
            if (cfg_wr_en) begin
                window_limit = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser[1:0], s_tdata[31:0], s_tdata[34:32], s_tuser[2]);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        fail_count    <= mismatches;
        pending_count <= due_frames.size();
    end

endmodule

### tb/tb_go_back_n_sender_core.sv
`timescale 1ns / 1ps

module tb_go_back_n_sender_core;

    import gbn_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE      = 20;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [SEQ_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending_count;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   cycle_count = 0;

    go_back_n_sender_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    gbn_sender_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input logic [1:0] req, input logic [DATA_BITS-1:0] payload,
                                input logic [SEQ_W-1:0] ack, input logic bad);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, ack, payload};
        s_tuser  = {bad, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 48) begin
            send_request(REQ_NEW, $urandom, SEQ_W'($urandom_range(7)), 1'($urandom_range(1)));
        end else if (pick < 78) begin
            send_request(REQ_ACK, $urandom, SEQ_W'($urandom_range(7)),
                         $urandom_range(9) == 0);
        end else if (pick < 95) begin
            send_request(REQ_TIMEOUT, $urandom, SEQ_W'($urandom_range(7)),
                         1'($urandom_range(1)));
        end else begin
            send_request(REQ_UNKNOWN, $urandom, SEQ_W'($urandom_range(7)),
                         1'($urandom_range(1)));
        end
    endtask

    task automatic quiesce_and_set_limit(input logic [SEQ_W-1:0] lim);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = lim;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [SEQ_W-1:0] lim, input int count);
        quiesce_and_set_limit(lim);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        quiesce_and_set_limit(3'd7);

        send_request(REQ_NEW, 32'h0000_0000, 3'd0, 1'b0);
        send_request(REQ_NEW, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_request(REQ_NEW, 32'hAAAA_AAAA, 3'd5, 1'b0);
        send_request(REQ_NEW, 32'h5555_5555, 3'd2, 1'b0);
        send_request(REQ_NEW, 32'h0000_0001, 3'd0, 1'b0);
        send_request(REQ_NEW, 32'h8000_0000, 3'd0, 1'b0);
        send_request(REQ_NEW, $urandom, 3'd0, 1'b0);
        send_request(REQ_NEW, $urandom, 3'd0, 1'b0);
        send_request(REQ_TIMEOUT, 32'h0, 3'd0, 1'b0);
        send_request(REQ_ACK, 32'h0, 3'd3, 1'b1);
        send_request(REQ_ACK, 32'h0, 3'd7, 1'b0);
        send_request(REQ_ACK, 32'h0, 3'd2, 1'b0);
        send_request(REQ_ACK, 32'h0, 3'd1, 1'b0);
        send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_request(REQ_TIMEOUT, 32'h0, 3'd0, 1'b1);
        send_request(REQ_ACK, 32'h0, 3'd6, 1'b0);
        send_request(REQ_TIMEOUT, 32'h0, 3'd0, 1'b0);
        send_request(REQ_ACK, 32'h0, 3'd7, 1'b0);
        send_request(REQ_NEW, $urandom, 3'd0, 1'b0);
        send_request(REQ_NEW, $urandom, 3'd0, 1'b0);
        send_request(REQ_NEW, $urandom, 3'd0, 1'b0);
        send_request(REQ_ACK, 32'h0, 3'd0, 1'b0);
        send_request(REQ_ACK, 32'h0, 3'd1, 1'b0);

        run_phase(0, 0, 3'd4, 110);
        run_phase(74, 0, 3'd7, 110);
        run_phase(30, 30, 3'd0, 12);
        run_phase(0, 74, 3'd1, 110);
        run_phase(30, 30, 3'd6, 110);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### go_back_n_sender_core.f
src/gbn_pkg.sv
src/gbn_ram.sv
src/gbn_front.sv
src/gbn_back.sv
src/go_back_n_sender_core.sv
tb/gbn_sender_checker.sv
tb/tb_go_back_n_sender_core.sv
